// ----- sv/rms_layer_normalizer_assert.svh -----
// assertion macros for the rms layer normalizer
`ifndef RMS_LAYER_NORMALIZER_ASSERT_SVH
`define RMS_LAYER_NORMALIZER_ASSERT_SVH
`ifndef SYNTH
`define RMSN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RMSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMSN_ASSERT(lbl, clk, rst, prop, msg)
`define RMSN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/rmsn_pkg.sv -----
// shared constants and controller/datapath interface types
package rmsn_pkg;

  localparam int ROW_LEN_W = 7;
  localparam int EPS_W = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 1'b1;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 7'd64;
  localparam logic [EPS_W-1:0] EPSILON_RESET = 21'd168;

  // reciprocal is 2^40 / rms, rms in q.20
  localparam int RECIP_SHIFT = 40;
  localparam int INV_W = 41;
  localparam int INV_SPLIT = 21;
  localparam int ROUND_SHIFT = 32;
  localparam int SQRT_PRESHIFT = 16;

  typedef struct packed {
    logic accept;
    logic mean_start;
    logic sqrt_load;
    logic sqrt_step;
    logic recip_start;
    logic inv_load;
    logic mag_load;
    logic plo_load;
    logic phi_load;
    logic out_load;
    logic k_inc;
  } cmd_t;

  typedef struct packed {
    logic final_item;
    logic div_done;
    logic sqrt_done;
    logic last_k;
  } status_t;

endpackage

// ----- sv/rms_layer_normalizer.sv -----
// top level of the rms layer normalizer
// usage:
//   sample channel: sample_valid/sample_stall carry one row element and its gain
//   per request. elements are collected until the count reaches row_length, then
//   the row is normalized and every element is sent back in arrival order on the
//   result channel (result_valid/result_stall), row_end marking the last one.
//   a non-final element is stored and produces no result.
//   after the last element of a row the block stalls the sample channel while it
//   divides the square sum by the count (one bit per cycle on a shared divider),
//   takes the square root (one bit pair per cycle) and forms the reciprocal on the
//   same divider. each result then passes through ram read, magnitude product, two
//   partial products of the reciprocal multiply, rounding and saturation.
//   a stalled result holds in the output register; the next element waits for it.
//   the sample channel reopens once the last result is registered.
//   config: write_enable/reg_index/write_data, only while no row is in flight.
//   reset clears count, sum and handshakes and restores row_length 64, epsilon 168.
module rms_layer_normalizer #(
  parameter int MAX_ROW = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [rmsn_pkg::CFG_DATA_W-1:0] write_data,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample_value,
  input  logic signed [SAMPLE_BITS-1:0]   gain_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [SAMPLE_BITS-1:0]   normalized_value,
  output logic                            row_end
);

  rmsn_pkg::cmd_t    cmd;
  rmsn_pkg::status_t status;

  rmsn_dp #(
    .MAX_ROW     (MAX_ROW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .write_enable     (write_enable),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .sample_value     (sample_value),
    .gain_value       (gain_value),
    .cmd              (cmd),
    .status           (status),
    .normalized_value (normalized_value),
    .row_end          (row_end)
  );

  rmsn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

endmodule

// ----- sv/rmsn_ram.sv -----
// generic single-write, single-read ram with registered read
module rmsn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rmsn_div.sv -----
// restoring divider, one quotient bit per cycle
module rmsn_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], ge};
    end
  end

endmodule

// ----- sv/rmsn_dp.sv -----
// datapath: config registers, row store, square sum, root, reciprocal and scaling
module rmsn_dp #(
  parameter int MAX_ROW = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_enable,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [rmsn_pkg::CFG_DATA_W-1:0]     write_data,
  input  logic signed [SAMPLE_BITS-1:0]       sample_value,
  input  logic signed [SAMPLE_BITS-1:0]       gain_value,
  input  rmsn_pkg::cmd_t                      cmd,
  output rmsn_pkg::status_t                   status,
  output logic signed [SAMPLE_BITS-1:0]       normalized_value,
  output logic                                row_end
);

  localparam int SB = SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_ROW + 1);
  localparam int ADDR_W = $clog2(MAX_ROW);
  localparam int SQ_W = 2 * SB - 1;
  localparam int SUM_W = SQ_W + $clog2(MAX_ROW);
  localparam int M_W = ((SUM_W > rmsn_pkg::EPS_W) ? SUM_W : rmsn_pkg::EPS_W) + 1;
  localparam int XR_W = M_W + rmsn_pkg::SQRT_PRESHIFT;
  localparam int X_W = XR_W + (XR_W % 2);
  localparam int R_W = X_W / 2;
  localparam int DVD_W = (SUM_W > rmsn_pkg::INV_W) ? SUM_W : rmsn_pkg::INV_W;
  localparam int DVS_W = (R_W > CNT_W) ? R_W : CNT_W;
  localparam int MAG_W = 2 * SB;
  localparam int PLO_W = MAG_W + rmsn_pkg::INV_SPLIT;
  localparam int PHI_W = MAG_W + rmsn_pkg::INV_W - rmsn_pkg::INV_SPLIT;
  localparam int ACC_W = MAG_W + rmsn_pkg::INV_W + 1;
  localparam int Q_W = ACC_W - rmsn_pkg::ROUND_SHIFT;
  localparam logic [DVD_W-1:0] RECIP_ONE = DVD_W'(1) << rmsn_pkg::RECIP_SHIFT;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (rmsn_pkg::ROUND_SHIFT - 1);
  localparam logic [Q_W-1:0] HI_Q = Q_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [SB-1:0] OUT_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0] OUT_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic [rmsn_pkg::ROW_LEN_W-1:0] MAX_LEN = rmsn_pkg::ROW_LEN_W'(MAX_ROW);

  logic [rmsn_pkg::ROW_LEN_W-1:0] row_length;
  logic [rmsn_pkg::EPS_W-1:0]     epsilon_q24;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               row_n;
  logic [SUM_W-1:0]               square_sum;
  logic [X_W-1:0]                 sx;
  logic [X_W-1:0]                 sres;
  logic [X_W-1:0]                 sbit;
  logic [rmsn_pkg::INV_W-1:0]     inv;
  logic [ADDR_W-1:0]              k;
  logic [MAG_W-1:0]               mag;
  logic                           neg;
  logic [PLO_W-1:0]               plo;
  logic [PHI_W-1:0]               phi;

  logic [rmsn_pkg::ROW_LEN_W-1:0] eff_len;
  logic [CNT_W-1:0]               n_next;
  logic signed [2*SB-1:0]         sq_full;
  logic [2*SB-1:0]                store_wdata;
  logic [2*SB-1:0]                store_rdata;
  logic [DVD_W-1:0]               div_dividend;
  logic [DVS_W-1:0]               div_divisor;
  logic [DVD_W-1:0]               div_quotient;
  logic                           div_done;
  logic [M_W-1:0]                 mean_sq;
  logic [X_W-1:0]                 sqrt_trial;
  logic [R_W-1:0]                 rms;
  logic [SB-1:0]                  a_val;
  logic [SB-1:0]                  g_val;
  logic [SB-1:0]                  abs_a;
  logic [SB-1:0]                  abs_g;
  logic [ACC_W-1:0]               acc;
  logic [Q_W-1:0]                 q;
  logic [SB-1:0]                  sat;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= rmsn_pkg::ROW_LENGTH_RESET;
      epsilon_q24 <= rmsn_pkg::EPSILON_RESET;
    end else if (write_enable) begin
      case (reg_index)
        rmsn_pkg::REG_ROW_LENGTH: row_length <= write_data[rmsn_pkg::ROW_LEN_W-1:0];
        rmsn_pkg::REG_EPSILON:    epsilon_q24 <= write_data[rmsn_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the store depth acts as the depth
  always_comb begin
    if (row_length == '0) begin
      eff_len = rmsn_pkg::ROW_LEN_W'(1);
    end else if (row_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = row_length;
    end
  end

  assign n_next = count + CNT_W'(1);
  assign sq_full = sample_value * sample_value;
  assign store_wdata = {gain_value, sample_value};

  assign status.final_item = rmsn_pkg::ROW_LEN_W'(n_next) >= eff_len;
  assign status.div_done = div_done;
  assign status.sqrt_done = (sbit == '0);
  assign status.last_k = (CNT_W'(k) + CNT_W'(1)) == row_n;

  rmsn_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_ROW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (count[ADDR_W-1:0]),
    .wdata (store_wdata),
    .raddr (k),
    .rdata (store_rdata)
  );

  // one divider serves the mean and the reciprocal
  assign div_dividend = cmd.mean_start ? DVD_W'(square_sum) : RECIP_ONE;
  assign div_divisor = cmd.mean_start ? DVS_W'(row_n) : DVS_W'(rms);

  rmsn_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mean_start || cmd.recip_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      square_sum <= '0;
    end else begin
      if (cmd.accept) begin
        square_sum <= square_sum + SUM_W'(sq_full[SQ_W-1:0]);
        count <= status.final_item ? '0 : n_next;
      end else if (cmd.mean_start) begin
        square_sum <= '0;
      end
    end
  end

  assign mean_sq = M_W'(div_quotient[SUM_W-1:0]) + M_W'(epsilon_q24);
  assign sqrt_trial = sres + sbit;
  assign rms = sres[R_W-1:0];

  assign a_val = store_rdata[SB-1:0];
  assign g_val = store_rdata[2*SB-1:SB];
  assign abs_a = a_val[SB-1] ? (~a_val + SB'(1)) : a_val;
  assign abs_g = g_val[SB-1] ? (~g_val + SB'(1)) : g_val;

  assign acc = ACC_W'(plo) + (ACC_W'(phi) << rmsn_pkg::INV_SPLIT) + ROUND_HALF;
  assign q = acc[ACC_W-1:rmsn_pkg::ROUND_SHIFT];

  // saturate to the signed output range, negative side reaches one further
  always_comb begin
    if (neg) begin
      sat = (q > HI_Q + Q_W'(1)) ? OUT_MIN : (~q[SB-1:0] + SB'(1));
    end else begin
      sat = (q > HI_Q) ? OUT_MAX : q[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.final_item) begin
      row_n <= n_next;
    end
    if (cmd.sqrt_load) begin
      sx <= X_W'({mean_sq, {rmsn_pkg::SQRT_PRESHIFT{1'b0}}});
      sres <= '0;
      sbit <= X_W'(1) << (X_W - 2);
    end else if (cmd.sqrt_step) begin
      if (sx >= sqrt_trial) begin
        sx <= sx - sqrt_trial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
    if (cmd.inv_load) begin
      inv <= (rms == '0) ? '0 : div_quotient[rmsn_pkg::INV_W-1:0];
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + ADDR_W'(1);
    end
    if (cmd.mag_load) begin
      mag <= MAG_W'(abs_a) * MAG_W'(abs_g);
      neg <= a_val[SB-1] ^ g_val[SB-1];
    end
    if (cmd.plo_load) begin
      plo <= PLO_W'(mag) * PLO_W'(inv[rmsn_pkg::INV_SPLIT-1:0]);
    end
    if (cmd.phi_load) begin
      phi <= PHI_W'(mag) * PHI_W'(inv[rmsn_pkg::INV_W-1:rmsn_pkg::INV_SPLIT]);
    end
    if (cmd.out_load) begin
      normalized_value <= sat;
      row_end <= status.last_k;
    end
  end

endmodule

// ----- sv/rmsn_ctrl.sv -----
// controller: request intake, row math sequencing and result emission
`include "rms_layer_normalizer_assert.svh"
module rmsn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  rmsn_pkg::status_t  status,
  output rmsn_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SQRT,
    S_RECIP_GO,
    S_RECIP_WAIT,
    S_RD,
    S_MAG,
    S_PLO,
    S_PHI,
    S_PUT
  } state_t;

  state_t state;

  assign sample_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.accept = (state == S_IDLE) && sample_valid;
    cmd.mean_start = (state == S_MEAN_GO);
    cmd.sqrt_load = (state == S_MEAN_WAIT) && status.div_done;
    cmd.sqrt_step = (state == S_SQRT) && !status.sqrt_done;
    cmd.recip_start = (state == S_RECIP_GO);
    cmd.inv_load = (state == S_RECIP_WAIT) && status.div_done;
    cmd.mag_load = (state == S_MAG);
    cmd.plo_load = (state == S_PLO);
    cmd.phi_load = (state == S_PHI);
    cmd.out_load = (state == S_PUT) && (!result_valid || !result_stall);
    cmd.k_inc = cmd.out_load && !status.last_k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.accept && status.final_item) begin
            state <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (status.div_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (status.sqrt_done) begin
            state <= S_RECIP_GO;
          end
        end
        S_RECIP_GO: state <= S_RECIP_WAIT;
        S_RECIP_WAIT: begin
          if (status.div_done) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_MAG;
        S_MAG: state <= S_PLO;
        S_PLO: state <= S_PHI;
        S_PHI: state <= S_PUT;
        S_PUT: begin
          if (cmd.out_load) begin
            state <= status.last_k ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RMSN_ASSERT(a_no_overwrite, clk, rst, (result_valid && result_stall) |-> !cmd.out_load, "result overwritten while stalled")
  `RMSN_ASSERT(a_row_closes, clk, rst, (cmd.accept && status.final_item) |=> sample_stall, "row end did not start normalization")
  `RMSN_ASSERT(a_div_done_place, clk, rst, status.div_done |-> (state == S_MEAN_WAIT || state == S_RECIP_WAIT), "divider finished outside a wait state")

endmodule

// ----- dv/tb_rms_layer_normalizer.sv -----
// testbench for the rms layer normalizer: directed table, random rows, scored against a predictor
module tb_rms_layer_normalizer;

  localparam int MAX_ROW = 64;
  localparam int SB = 16;
  localparam int DIRECTED_ROWS = 25;
  localparam int IDX_W = rmsn_pkg::CFG_IDX_W;
  localparam int CFG_W = rmsn_pkg::CFG_DATA_W;

  typedef struct {
    logic signed [SB-1:0] smp;
    logic signed [SB-1:0] gn;
    bit                   has_norm;
    logic signed [SB-1:0] norm;
  } stim_row_t;

  typedef struct {
    logic signed [SB-1:0] norm;
    logic                 last;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [IDX_W-1:0] reg_index = '0;
  logic [CFG_W-1:0] write_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SB-1:0] sample_value = '0;
  logic signed [SB-1:0] gain_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [SB-1:0] normalized_value;
  logic row_end;

  rms_layer_normalizer #(.MAX_ROW(MAX_ROW), .SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst), .write_enable(write_enable), .reg_index(reg_index),
    .write_data(write_data), .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_value(sample_value), .gain_value(gain_value), .result_valid(result_valid),
    .result_stall(result_stall), .normalized_value(normalized_value), .row_end(row_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [6:0]         row_len_q;
  logic [20:0]        eps_q;
  logic signed [SB-1:0] smp_mem [MAX_ROW];
  logic signed [SB-1:0] gain_mem [MAX_ROW];
  int unsigned        elem_cnt;
  logic [36:0]        sq_sum;

  norm_result_t       pending_norms[$];
  logic signed [SB-1:0] pinned_norm[$];
  bit                 pinned_valid[$];

  int errors = 0;
  int results_seen = 0;
  int rows_done = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  logic hold_active = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    if (idx == rmsn_pkg::REG_ROW_LENGTH) row_len_q = val[6:0];
    else if (idx == rmsn_pkg::REG_EPSILON) eps_q = val[20:0];
  endfunction

  // accumulate one element and, at the row end, queue the normalized row
  function automatic void predict_normalize(logic signed [SB-1:0] s, logic signed [SB-1:0] g);
    int unsigned idx, n, eff, k;
    longint unsigned m, r, inv, mag, q, as, ag;
    longint signed v;
    norm_result_t nr;
    idx = (elem_cnt >= MAX_ROW) ? MAX_ROW - 1 : elem_cnt;
    smp_mem[idx] = s;
    gain_mem[idx] = g;
    as = (s < 0) ? -longint'(s) : longint'(s);
    sq_sum += as * as;
    n = idx + 1;
    eff = (row_len_q == 0) ? 1 : (row_len_q > MAX_ROW) ? MAX_ROW : row_len_q;
    if (n < eff) begin
      elem_cnt = n;
      return;
    end
    m = longint'(sq_sum) / n + eps_q;
    r = int_sqrt(m << 16);
    inv = (r != 0) ? (64'd1 << 40) / r : 0;
    for (k = 0; k < n; k++) begin
      as = (smp_mem[k] < 0) ? -longint'(smp_mem[k]) : longint'(smp_mem[k]);
      ag = (gain_mem[k] < 0) ? -longint'(gain_mem[k]) : longint'(gain_mem[k]);
      mag = as * ag;
      q = (mag * inv + (64'd1 << 31)) >> 32;
      if ((smp_mem[k] < 0) != (gain_mem[k] < 0)) v = (q > 32768) ? -32768 : -longint'(q);
      else v = (q > 32767) ? 32767 : longint'(q);
      nr.norm = v[SB-1:0];
      nr.last = (k + 1 == n);
      pending_norms.push_back(nr);
    end
    elem_cnt = 0;
    sq_sum = 0;
  endfunction

  // long receiver hold-off while the sender keeps offering requests
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (400) @(posedge clk);
    hold_active <= 1'b0;
  end

  // result side: stall and score
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (pending_norms.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %0d row_end %0b",
                   $time, normalized_value, row_end);
        end else begin
          norm_result_t e;
          logic signed [SB-1:0] want;
          bit pin;
          e = pending_norms.pop_front();
          pin = pinned_valid.size() ? pinned_valid.pop_front() : 1'b0;
          want = pinned_norm.size() ? pinned_norm.pop_front() : e.norm;
          if (pin && want !== e.norm) begin
            errors++;
            $display("%0t: table entry disagrees with predictor: %0d vs %0d",
                     $time, want, e.norm);
          end
          if (normalized_value !== e.norm) begin
            errors++;
            $display("%0t: normalized_value expected %0d actual %0d",
                     $time, e.norm, normalized_value);
          end
          if (row_end !== e.last) begin
            errors++;
            $display("%0t: row_end expected %0b actual %0b", $time, e.last, row_end);
          end
          if (e.last) rows_done++;
        end
      end
      if (hold_active) begin
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // valid stays up after acceptance so requests can follow back to back
  task automatic send_request(logic signed [SB-1:0] s, logic signed [SB-1:0] g);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= s;
    gain_value <= g;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_normalize(s, g);
  endtask

  task automatic drain_rows();
    sample_valid <= 1'b0;
    while (pending_norms.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    @(posedge clk);
    apply_register(idx, val);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_q412();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh1000;
      default: return SB'($urandom);
    endcase
  endfunction

  task automatic send_random_row(int unsigned len);
    int unsigned j;
    for (j = 0; j < len; j++) send_request(rand_q412(), rand_q412());
  endtask

  initial begin
    stim_row_t dir_tbl[DIRECTED_ROWS];
    int i, ph;
    row_len_q = rmsn_pkg::ROW_LENGTH_RESET;
    eps_q = rmsn_pkg::EPSILON_RESET;
    elem_cnt = 0;
    sq_sum = 0;
    // row length 1, epsilon 0: s*g over |s| with ties away from zero
    dir_tbl[0] = '{16'sh1000, 16'sh1000, 1'b1, 16'sh1000};
    dir_tbl[1] = '{-16'sh1000, 16'sh1000, 1'b1, -16'sh1000};
    dir_tbl[2] = '{16'sh7fff, 16'sh7fff, 1'b1, 16'sh7fff};
    dir_tbl[3] = '{16'sh8000, 16'sh7fff, 1'b1, 16'sh8001};
    dir_tbl[4] = '{16'sh8000, 16'sh8000, 1'b1, 16'sh7fff};
    dir_tbl[5] = '{16'sh0000, 16'sh7fff, 1'b1, 16'sh0000};
    dir_tbl[6] = '{16'sh0001, 16'shffff, 1'b1, 16'shffff};
    dir_tbl[7] = '{16'sh2000, -16'sh1000, 1'b1, -16'sh1000};
    for (i = 8; i < DIRECTED_ROWS; i++) dir_tbl[i] = '{SB'($urandom), SB'($urandom), 1'b0, '0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default row of 64 with all-zero gain after reset
    for (i = 0; i < 64; i++) begin
      pinned_valid.push_back(1'b1);
      pinned_norm.push_back('0);
      send_request(SB'($urandom), '0);
    end
    drain_rows();

    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(1));
    write_register(rmsn_pkg::REG_EPSILON, CFG_W'(0));
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      pinned_valid.push_back(dir_tbl[i].has_norm);
      pinned_norm.push_back(dir_tbl[i].norm);
      send_request(dir_tbl[i].smp, dir_tbl[i].gn);
    end
    drain_rows();
    pinned_valid.delete();
    pinned_norm.delete();

    // all-zero row with zero epsilon gives zero reciprocal
    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(3));
    for (i = 0; i < 3; i++) send_request('0, SB'($urandom));
    drain_rows();
    // zero length acts as one, oversize acts as maximum, epsilon at its top
    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(0));
    write_register(rmsn_pkg::REG_EPSILON, 21'h100000);
    send_random_row(2);
    drain_rows();
    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(127));
    write_register(rmsn_pkg::REG_EPSILON, 21'h1fffff);
    send_random_row(64);
    drain_rows();
    // lower the length mid-row: the row ends with what is stored
    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(8));
    send_random_row(5);
    drain_rows();
    write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'(4));
    send_random_row(1);
    drain_rows();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 37) : 0;
      recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 37 : 0;
      write_register(rmsn_pkg::REG_ROW_LENGTH, CFG_W'($urandom_range(1, 12)));
      write_register(rmsn_pkg::REG_EPSILON, CFG_W'($urandom_range(0, 1048576)));
      if (ph == 0) hold_go = 1'b1;
      for (i = 0; i < 25; i++) send_random_row(1);
      send_random_row($urandom_range(0, 3));
      while (elem_cnt != 0) send_random_row(1);
      drain_rows();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    $display("covered %0d rows, %0d results, length extremes, zero and top epsilon, stalls",
             rows_done, results_seen);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/rmsn_pkg.sv
sv/rmsn_ram.sv
sv/rmsn_div.sv
sv/rmsn_dp.sv
sv/rmsn_ctrl.sv
sv/rms_layer_normalizer.sv
dv/tb_rms_layer_normalizer.sv
